FILE: rtl/core/raster_bin_2x2_downsample_macros.svh
// Assertion macros used by the binning output stage.
`ifndef RASTER_BIN_2X2_DOWNSAMPLE_MACROS_SVH
`define RASTER_BIN_2X2_DOWNSAMPLE_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define RBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rbd: same-cycle check failed");

// Next-cycle implication, reset masks the check.
`define RBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rbd: next-cycle check failed");

`endif

FILE: rtl/core/rbd_pkg.sv
// Shared constants and types of the 2x2 raster binning block.
`default_nettype none
package rbd_pkg;

	localparam int MAX_ROW_SAMPLES_DEF = 1024;
	localparam int SAMPLE_BITS_DEF     = 24;

	// configuration register layout
	localparam int CFG_W       = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int ROW_W       = 10;
	localparam logic [CFG_W-1:0] ROW_LIMIT = CFG_W'(1024);
	localparam logic [CFG_W-1:0] DIM_MIN   = CFG_W'(2);

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SAMPLES_PER_ROW = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS_PER_FRAME  = CFG_IDX_W'(1);

	// per-item control from the raster tracker to the output stages
	typedef struct packed {
		logic result;
		logic row_end;
		logic frame_end;
	} rbd_item_t;

endpackage
`default_nettype wire

FILE: rtl/core/raster_bin_2x2_downsample.sv
// Top level of the 2x2 raster binning block.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------------
//  s_*     | in  | s_tvalid / s_tready | tdata: sample (SAMPLE_BITS, signed)
//  m_*     | out | m_tvalid / m_tready | tdata: binned; tlast: row_end; tuser: frame_end
//  cfg_*   | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (11 bits)
//
// One sample is taken every cycle while s_tready is high; the limit is the single
// add of a pair sum and one line-store access per sample. The odd-row, odd-column
// sample ending a 2x2 block passes the align stage, then the output register.
// Reset clears counters, held sample and limits (1024 x 1024); the line store
// needs no clearing pass, as each entry is written on an even row before use.
// A stalled output holds its request; s_tready drops only when both the
// align stage and the output register hold results.
`default_nettype none
module raster_bin_2x2_downsample
	import rbd_pkg::*;
#(
	parameter int MAX_ROW_SAMPLES = MAX_ROW_SAMPLES_DEF,
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_BITS + 2 + 7) / 8) * 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input sample stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_W-1:0]      s_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
	// binned result stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [OUT_W-1:0]          m_tdata,   // [SAMPLE_BITS+1:0] binned, rest zero
	output logic                      m_tlast,   // row_end
	output logic [0:0]                m_tuser,   // [0] frame_end
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);
	localparam int COL_W  = $clog2(MAX_ROW_SAMPLES);
	localparam int SLOT_W = COL_W - 1;
	localparam int DEPTH  = MAX_ROW_SAMPLES / 2;

	logic                   take;
	logic                   wr_en, rd_en;
	logic [SLOT_W-1:0]      slot;
	logic [SAMPLE_BITS:0]   pair;
	logic [SAMPLE_BITS:0]   line_pair;
	rbd_item_t              item;
	logic [SAMPLE_BITS+1:0] binned;
	logic                   frame_end;

	// register writes are always taken at once
	assign cfg_ready = 1'b1;
	assign take      = s_tvalid & s_tready;

	rbd_raster_ctrl #(
		.MAX_ROW_SAMPLES(MAX_ROW_SAMPLES),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.take     (take),
		.sample   (s_tdata[SAMPLE_BITS-1:0]),
		.wr_en    (wr_en),
		.rd_en    (rd_en),
		.slot     (slot),
		.pair     (pair),
		.item     (item)
	);

	// even rows write pair sums, odd rows read them back; never both at once
	rbd_line_mem #(
		.DEPTH (DEPTH),
		.ADDR_W(SLOT_W),
		.DATA_W(SAMPLE_BITS + 1)
	) u_line (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(slot),
		.wr_data(pair),
		.rd_en  (rd_en),
		.rd_addr(slot),
		.rd_data(line_pair)
	);

	rbd_out_stage #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.item         (item),
		.pair         (pair),
		.line_pair    (line_pair),
		.in_ready     (s_tready),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_binned   (binned),
		.out_row_end  (m_tlast),
		.out_frame_end(frame_end)
	);

	assign m_tdata    = OUT_W'(binned);
	assign m_tuser[0] = frame_end;
endmodule
`default_nettype wire

FILE: rtl/core/rbd_raster_ctrl.sv
// Config registers, raster counters, held sample and horizontal pair add.
`default_nettype none
module rbd_raster_ctrl
	import rbd_pkg::*;
#(
	parameter int MAX_ROW_SAMPLES = MAX_ROW_SAMPLES_DEF,
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	localparam int COL_W  = $clog2(MAX_ROW_SAMPLES),
	localparam int SLOT_W = COL_W - 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data,
	input  wire logic                   take,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	output logic                        wr_en,
	output logic                        rd_en,
	output logic [SLOT_W-1:0]           slot,
	output logic [SAMPLE_BITS:0]        pair,
	output rbd_item_t                   item
);
	localparam int MAXC_W = $clog2(MAX_ROW_SAMPLES + 1);
	localparam int CW     = (MAXC_W > CFG_W) ? MAXC_W : CFG_W;
	localparam logic [CW-1:0] MAX_COLS = CW'(MAX_ROW_SAMPLES);

	logic [CFG_W-1:0]       spr_q, rpf_q;
	logic [COL_W-1:0]       col_q;
	logic [ROW_W-1:0]       row_q;
	logic [SAMPLE_BITS-1:0] held_q;

	logic [CW-1:0]    cols, last_col, col_inc;
	logic [CFG_W-1:0] rows, last_row, row_inc;
	logic             col_wrap, row_wrap;

	always_comb begin
		// out-of-range limits act as the nearest legal value
		if (spr_q < DIM_MIN) begin
			cols = CW'(DIM_MIN);
		end else if (CW'(spr_q) > MAX_COLS) begin
			cols = MAX_COLS;
		end else begin
			cols = CW'(spr_q);
		end
		if (rpf_q < DIM_MIN) begin
			rows = DIM_MIN;
		end else if (rpf_q > ROW_LIMIT) begin
			rows = ROW_LIMIT;
		end else begin
			rows = rpf_q;
		end
		last_col = {cols[CW-1:1], 1'b0} - CW'(1);
		last_row = {rows[CFG_W-1:1], 1'b0} - CFG_W'(1);
		col_inc  = CW'(col_q) + CW'(1);
		row_inc  = CFG_W'(row_q) + CFG_W'(1);
		col_wrap = (col_inc >= cols);
		row_wrap = (row_inc >= rows);
	end

	assign pair = {held_q[SAMPLE_BITS-1], held_q} + {sample[SAMPLE_BITS-1], sample};
	assign slot = col_q[COL_W-1:1];

	assign wr_en = take & col_q[0] & ~row_q[0];
	assign rd_en = take & col_q[0] & row_q[0];

	assign item.result    = col_q[0] & row_q[0];
	assign item.row_end   = (CW'(col_q) == last_col);
	assign item.frame_end = item.row_end & (CFG_W'(row_q) == last_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q  <= CFG_W'(1024);
			rpf_q  <= CFG_W'(1024);
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					CFG_IDX_SAMPLES_PER_ROW: spr_q <= cfg_data;
					CFG_IDX_ROWS_PER_FRAME:  rpf_q <= cfg_data;
					default: ;
				endcase
			end
			if (take) begin
				if (!col_q[0]) begin
					held_q <= sample;
				end
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_inc[ROW_W-1:0];
				end else begin
					col_q <= col_inc[COL_W-1:0];
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/rbd_line_mem.sv
// Line store of even-row pair sums, one write and one registered read port.
`default_nettype none
module rbd_line_mem #(
	parameter int DEPTH  = 512,
	parameter int ADDR_W = 9,
	parameter int DATA_W = 25
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);
	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/rbd_out_stage.sv
// Pair-align stage and output register: adds stored and new pair sums.
`default_nettype none
module rbd_out_stage
	import rbd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   take,
	input  wire rbd_item_t              item,
	input  wire logic [SAMPLE_BITS:0]   pair,
	input  wire logic [SAMPLE_BITS:0]   line_pair,
	output logic                        in_ready,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [SAMPLE_BITS+1:0]      out_binned,
	output logic                        out_row_end,
	output logic                        out_frame_end
);
	`include "raster_bin_2x2_downsample_macros.svh"

	logic                 v_s1;
	logic                 row_end_s1, frame_end_s1;
	logic [SAMPLE_BITS:0] pair_s1;
	logic                 adv;
	logic                 load;

	assign adv      = ~out_valid | out_ready;
	assign in_ready = ~v_s1 | adv;
	assign load     = take & item.result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pair_s1      <= pair;
			row_end_s1   <= item.row_end;
			frame_end_s1 <= item.frame_end;
		end
		if (adv && v_s1) begin
			out_binned    <= {line_pair[SAMPLE_BITS], line_pair}
				+ {pair_s1[SAMPLE_BITS], pair_s1};
			out_row_end   <= row_end_s1;
			out_frame_end <= frame_end_s1;
		end
	end

	`RBD_ASSERT_NOW(a_frame_end_on_row_end, clk, arst_n, out_valid && out_frame_end, out_row_end)
	`RBD_ASSERT_NEXT(a_load_fills_s1, clk, arst_n, load, v_s1)
	`RBD_ASSERT_NEXT(a_s1_moves_out, clk, arst_n, adv && v_s1, out_valid)
endmodule
`default_nettype wire
